@@ hdl/mrv_pkg.sv @@
// Shared types, constants and the CRC16 byte update for the request validator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mrv_pkg;

   // frame byte counter, saturating
   localparam int          LEN_W      = 9;
   localparam logic [8:0]  LEN_SAT    = 9'd511;
   localparam int          HDR_BYTES  = 7;

   // crc16, reflected polynomial
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   // function codes
   localparam logic [7:0]  FN_READ_COILS  = 8'h01;
   localparam logic [7:0]  FN_READ_INPUTS = 8'h02;
   localparam logic [7:0]  FN_WRITE_COIL  = 8'h05;
   localparam logic [7:0]  FN_WRITE_COILS = 8'h0F;

   // request limits
   localparam logic [15:0] READ_QTY_MAX  = 16'd2000;
   localparam logic [15:0] WRITE_QTY_MAX = 16'd1968;
   localparam logic [15:0] COIL_ON_VALUE = 16'hFF00;
   localparam logic [15:0] COIL_OFF_VALUE = 16'h0000;
   localparam logic [LEN_W-1:0] LEN_MIN_FRAME = 9'd4;
   localparam logic [LEN_W-1:0] LEN_MIN_READ  = 9'd8;
   localparam logic [LEN_W-1:0] LEN_MIN_MULTI = 9'd9;

   // configuration register indexes
   localparam logic [1:0]  CSR_SLAVE_ADDRESS = 2'd0;

   typedef enum logic [1:0] {
      VERDICT_DROP      = 2'd0,
      VERDICT_REPLY     = 2'd1,
      VERDICT_SILENT    = 2'd2,
      VERDICT_EXCEPTION = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      EXC_NONE             = 2'd0,
      EXC_ILLEGAL_FUNCTION = 2'd1,
      EXC_ILLEGAL_VALUE    = 2'd2
   } exception_type;

   // frame as captured on the word that ends it
   typedef struct packed {
      logic [LEN_W-1:0]                len;
      logic [HDR_BYTES-1:0][7:0]       hdr;
      logic [15:0]                     crc;
      logic [15:0]                     rx_crc;
   } snap_type;

   // decoded verdict word
   typedef struct packed {
      verdict_type   verdict;
      logic [7:0]    function_code;
      logic [15:0]   start_address;
      logic [15:0]   quantity;
      logic          coil_on;
      logic [7:0]    data_bytes;
      exception_type exception_code;
   } rsp_type;

   // one byte through the modbus crc16
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/modbus_rtu_request_validator_unit.sv @@
// Top level of the Modbus RTU request validator: register port and the two
// pipeline stages. Uses mrv_pkg, mrv_frame_acc and mrv_check.
//
// Received request bytes come in one word per cycle on the req_ stream, with
// tlast marking the frame end. One verdict word leaves on the rsp_ stream for
// each frame once its last byte is taken: the crc byte update runs and the
// frame is captured into the snapshot register, then the frame checks and
// decode run into the result register. A byte is taken every cycle
// while results are drained; req_tready drops only when both the capture
// register and the result register hold words that cannot move on. A frame
// counts as dropped when shorter than four bytes, longer than
// MAX_FRAME_BYTES, with a bad crc, for another station, or as a broadcast
// read or a broadcast with an error. slave_address sits at byte address 0
// and resets to 1; change it only while no frame is in progress.
`default_nettype none

module modbus_rtu_request_validator_unit #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request byte stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tlast,   // frame_end
   // verdict stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] function_code, [23:8] start_address, [39:24] quantity, [40] coil_on,
   // [48:41] data_bytes, [50:49] exception_code, [55:51] zero
   output      logic [55:0] rsp_tdata,
   output      logic [1:0]  rsp_tuser,   // [1:0] verdict
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import mrv_pkg::*;

   logic [7:0] slave_address_ff;
   logic       csr_write;
   logic       snap_valid, snap_ready;
   snap_type   snap;
   rsp_type    rsp;

   // register port, single 8-bit register read back in a 32-bit word
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
      end else if (csr_write && ((csr_paddr >> 2) == CSR_SLAVE_ADDRESS)) begin
         slave_address_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = ((csr_paddr >> 2) == CSR_SLAVE_ADDRESS) ?
                       {24'h000000, slave_address_ff} : 32'h00000000;

   // byte accumulation and frame capture
   mrv_frame_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // checks and decode
   mrv_check #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_address_ff),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_rsp       (rsp)
   );

   // result word packing
   assign rsp_tuser = rsp.verdict;
   assign rsp_tdata = {5'b00000, rsp.exception_code, rsp.data_bytes, rsp.coil_on,
                       rsp.quantity, rsp.start_address, rsp.function_code};

endmodule

`default_nettype wire

@@ hdl/mrv_frame_acc.sv @@
// Per-frame accumulator: running crc, byte count, header and tail bytes,
// and a snapshot register loaded on the frame-end word. Uses mrv_pkg.
`default_nettype none

module mrv_frame_acc (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output      logic              snap_valid,
   input  wire logic              snap_ready,
   output      mrv_pkg::snap_type snap
);
   import mrv_pkg::*;

   logic [15:0]                crc_ff, crc_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [HDR_BYTES-1:0][7:0]  hdr_ff, hdr_in;
   logic [1:0][7:0]            tail_ff, tail_in;
   logic                       snap_valid_ff;
   snap_type                   snap_ff;
   logic                       accept;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   // state after taking this byte; crc trails the input by two bytes
   always_comb begin
      crc_in = crc_ff;
      if (len_ff >= LEN_W'(2)) begin
         crc_in = crc_byte(crc_ff, tail_ff[0]);
      end
      tail_in[0] = tail_ff[1];
      tail_in[1] = in_byte;
      hdr_in = hdr_ff;
      if (len_ff < LEN_W'(HDR_BYTES)) begin
         hdr_in[len_ff[2:0]] = in_byte;
      end
      len_in = (len_ff < LEN_SAT) ? len_ff + LEN_W'(1) : len_ff;
   end

   // frame state, reloaded after each frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         len_ff  <= '0;
         hdr_ff  <= '0;
         tail_ff <= '0;
      end else if (accept) begin
         if (in_last) begin
            crc_ff  <= CRC_INIT;
            len_ff  <= '0;
            hdr_ff  <= '0;
            tail_ff <= '0;
         end else begin
            crc_ff  <= crc_in;
            len_ff  <= len_in;
            hdr_ff  <= hdr_in;
            tail_ff <= tail_in;
         end
      end
   end

   // snapshot of a finished frame
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (accept && in_last) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_ready) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_last) begin
         snap_ff.len    <= len_in;
         snap_ff.hdr    <= hdr_in;
         snap_ff.crc    <= crc_in;
         snap_ff.rx_crc <= {tail_in[1], tail_in[0]};
      end
   end

endmodule

`default_nettype wire

@@ hdl/mrv_check.sv @@
// Frame checks and request decode from a captured frame, into the result
// register with its handshake. Uses mrv_pkg.
`default_nettype none

module mrv_check #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        slave_address,
   input  wire logic              snap_valid,
   output      logic              snap_ready,
   input  wire mrv_pkg::snap_type snap,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      mrv_pkg::rsp_type  out_rsp
);
   import mrv_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

   logic          out_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [7:0]    addr, fc, bc;
   logic [15:0]   sa, q;
   logic [16:0]   q_plus;
   logic [13:0]   q_bytes;
   logic [9:0]    bc_lim;
   logic          bcast, drop, is_read;
   exception_type exc;
   verdict_type   verdict;
   logic          coil_on;
   logic [7:0]    data_bytes;

   assign snap_ready = !out_valid_ff || out_ready;
   assign out_valid  = out_valid_ff;
   assign out_rsp    = rsp_ff;

   // header fields
   assign addr    = snap.hdr[0];
   assign fc      = snap.hdr[1];
   assign sa      = {snap.hdr[2], snap.hdr[3]};
   assign q       = {snap.hdr[4], snap.hdr[5]};
   assign bc      = snap.hdr[6];
   assign bcast   = (addr == 8'h00);
   assign q_plus  = {1'b0, q} + 17'd7;
   assign q_bytes = q_plus[16:3];
   assign bc_lim  = 10'd9 + {2'b00, bc};
   assign is_read = (fc == FN_READ_COILS) || (fc == FN_READ_INPUTS);

   // per-function checks
   always_comb begin
      drop       = (snap.len < LEN_MIN_FRAME) || (snap.len > LEN_MAX) ||
                   (snap.crc != snap.rx_crc) ||
                   (!bcast && (addr != slave_address));
      exc        = EXC_NONE;
      coil_on    = 1'b0;
      data_bytes = 8'h00;
      unique case (fc)
         FN_READ_COILS, FN_READ_INPUTS: begin
            if (bcast) begin
               drop = 1'b1;
            end else if ((snap.len < LEN_MIN_READ) || (q == 16'h0000) ||
                         (q > READ_QTY_MAX)) begin
               exc = EXC_ILLEGAL_VALUE;
            end else begin
               data_bytes = q_bytes[7:0];
            end
         end
         FN_WRITE_COIL: begin
            if ((snap.len < LEN_MIN_READ) ||
                ((q != COIL_OFF_VALUE) && (q != COIL_ON_VALUE))) begin
               exc = EXC_ILLEGAL_VALUE;
            end
            coil_on = (q == COIL_ON_VALUE);
         end
         FN_WRITE_COILS: begin
            data_bytes = bc;
            if ((snap.len < LEN_MIN_MULTI) || (q == 16'h0000) ||
                (q > WRITE_QTY_MAX) || ({6'd0, bc} != q_bytes) ||
                ({1'b0, snap.len} < bc_lim)) begin
               exc = EXC_ILLEGAL_VALUE;
            end
         end
         default: begin
            exc = EXC_ILLEGAL_FUNCTION;
         end
      endcase
   end

   // verdict and final field masking
   always_comb begin
      priority if (drop || (bcast && (exc != EXC_NONE))) begin
         verdict = VERDICT_DROP;
      end else if (bcast) begin
         verdict = VERDICT_SILENT;
      end else if (exc != EXC_NONE) begin
         verdict = VERDICT_EXCEPTION;
      end else begin
         verdict = VERDICT_REPLY;
      end
      rsp_in.verdict        = verdict;
      rsp_in.function_code  = fc;
      rsp_in.start_address  = sa;
      rsp_in.quantity       = q;
      rsp_in.coil_on        = coil_on;
      rsp_in.data_bytes     = (is_read && (verdict != VERDICT_REPLY)) ? 8'h00 : data_bytes;
      rsp_in.exception_code = (verdict == VERDICT_EXCEPTION) ? exc : EXC_NONE;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         out_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready && snap_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
